>>> rtl/dchs_pkg.sv
package dchs_pkg;

    localparam int SEC_W   = 32;
    localparam int CNT_W   = 7;
    localparam int ADDR_W  = 20;
    localparam int SPT_W   = 6;
    localparam int HEAD_W  = 8;
    localparam int SHIFT_W = 4;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam int DEF_MAX_COUNT = 64;
    localparam int DEF_MAX_SPT   = 63;

    localparam int QDEPTH = 2;

    // divider: 32-bit dividend, 8-bit divisor, two quotient bits a cycle
    localparam int NUM_W     = SEC_W;
    localparam int DEN_W     = HEAD_W;
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = NUM_W / DIV_RADIX;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_DRIVE = 2'd2;

    localparam logic [IDX_W-1:0] REG_SPT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEADS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PSTART = 3'd2;
    localparam logic [IDX_W-1:0] REG_PSIZE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT  = 3'd4;

    localparam logic [SPT_W-1:0]   RST_SPT    = 6'd18;
    localparam logic [HEAD_W-1:0]  RST_HEADS  = 8'd2;
    localparam logic [SEC_W-1:0]   RST_PSTART = 32'd0;
    localparam logic [SEC_W-1:0]   RST_PSIZE  = 32'd2880;
    localparam logic [SHIFT_W-1:0] RST_SHIFT  = 4'd9;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEC_W-1:0]  abs_sector;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] addr;
        logic              wr;
    } cmd_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
        logic [DEN_W-1:0]  rem;
    } div_res_t;

endpackage

>>> rtl/dchs_front.sv
module dchs_front
    import dchs_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SEC_W-1:0]  s_start_sector,
    input  logic [CNT_W-1:0]  s_sector_count,
    input  logic [ADDR_W-1:0] s_buffer_address,
    input  logic              s_is_write,
    input  logic [SPT_W-1:0]  spt,
    input  logic [HEAD_W-1:0] heads,
    input  logic [SEC_W-1:0]  part_start,
    input  logic [SEC_W-1:0]  part_size,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    localparam int CNT_MAXV = (1 << CNT_W) - 1;
    localparam int CNT_LIM  = (MAX_COUNT > CNT_MAXV) ? CNT_MAXV : MAX_COUNT;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_LIM[CNT_W-1:0];

    logic [CNT_W-1:0] count_sat;
    logic [SEC_W:0]   end_sector;
    logic             no_drive;
    logic             out_of_range;

    assign count_sat    = (s_sector_count > CNT_CAP) ? CNT_CAP : s_sector_count;
    assign end_sector   = {1'b0, s_start_sector} + {{(SEC_W+1-CNT_W){1'b0}}, count_sat};
    assign no_drive     = (heads == '0) || (spt == '0);
    assign out_of_range = (part_size == '0) || (end_sector > {1'b0, part_size});

    assign s_ready = !q_full;

    always_comb begin
        q_cmd.abs_sector = s_start_sector + part_start;
        q_cmd.count      = count_sat;
        q_cmd.addr       = s_buffer_address;
        q_cmd.wr         = s_is_write;
        if (no_drive) begin
            q_cmd.status = STATUS_NO_DRIVE;
        end else if (out_of_range) begin
            q_cmd.status = STATUS_RANGE;
        end else begin
            q_cmd.status = STATUS_OK;
        end
    end

    // a valid request of zero sectors leaves nothing to do
    assign q_push = s_valid && !q_full &&
                    !((q_cmd.status == STATUS_OK) && (count_sat == '0));

endmodule

>>> rtl/dchs_queue.sv
module dchs_queue
    import dchs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FILL_W = $clog2(QDEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = QDEPTH[FILL_W-1:0];
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QDEPTH - 1);

    cmd_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FILL_MAX);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !do_pop)
        else $error("queue popped while empty");
`endif

endmodule

>>> rtl/dchs_div.sv
module dchs_div
    import dchs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output div_res_t         res
);

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [DEN_W-1:0]  rem_next;

    always_comb begin
        logic [DEN_W:0]   trial;
        logic [NUM_W-1:0] q;
        logic [DEN_W-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_RADIX; i++) begin
            trial = {r, q[NUM_W-1]};
            q = {q[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                q[0]  = 1'b1;
            end
            r = trial[DEN_W-1:0];
        end
        quo_next = q;
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
                step_reg <= '0;
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !run_reg)
        else $error("divider restarted mid-run");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

>>> rtl/dchs_back.sv
module dchs_back
    import dchs_pkg::*;
#(
    parameter int MAX_SPT = DEF_MAX_SPT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SPT_W-1:0]   spt,
    input  logic [HEAD_W-1:0]  heads,
    input  logic [SHIFT_W-1:0] shift,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               div_start,
    output logic [NUM_W-1:0]   div_dividend,
    output logic [DEN_W-1:0]   div_divisor,
    input  div_res_t           div_res,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [SEC_W-1:0]   m_cylinder,
    output logic [HEAD_W-1:0]  m_head,
    output logic [SPT_W-1:0]   m_sector,
    output logic [CNT_W-1:0]   m_chunk_sectors,
    output logic [ADDR_W-1:0]  m_chunk_address,
    output logic               m_dma_wrap,
    output logic               m_write_out,
    output logic               m_last
);

    localparam int SPT_MAXV = (1 << SPT_W) - 1;
    localparam int SPT_LIM  = (MAX_SPT > SPT_MAXV) ? SPT_MAXV : MAX_SPT;
    localparam logic [SPT_W-1:0] SPT_CAP = SPT_LIM[SPT_W-1:0];
    localparam int BYTES_W = SPT_W + 15;
    localparam int WRAP_W  = BYTES_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SPT,
        ST_DIV_HEAD,
        ST_CHUNK,
        ST_EMIT
    } state_t;

    state_t             state_reg,   state_next;
    logic [SEC_W-1:0]   abs_reg,     abs_next;
    logic               carry_reg,   carry_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic               wr_reg,      wr_next;
    logic [SPT_W-1:0]   sec0_reg,    sec0_next;
    logic [HEAD_W-1:0]  head_reg,    head_next;
    logic [SEC_W-1:0]   cyl_reg,     cyl_next;

    logic               m_valid_reg,  m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [SEC_W-1:0]   m_cyl_reg,    m_cyl_next;
    logic [HEAD_W-1:0]  m_head_reg,   m_head_next;
    logic [SPT_W-1:0]   m_sec_reg,    m_sec_next;
    logic [CNT_W-1:0]   m_cnt_reg,    m_cnt_next;
    logic [ADDR_W-1:0]  m_addr_reg,   m_addr_next;
    logic               m_wrap_reg,   m_wrap_next;
    logic               m_wr_reg,     m_wr_next;
    logic               m_last_reg,   m_last_next;

    logic [SPT_W-1:0]   spt_eff;
    logic [SPT_W-1:0]   track_left;
    logic [SPT_W-1:0]   take;
    logic [BYTES_W-1:0] bytes;
    logic [WRAP_W-1:0]  wrap_sum;
    logic [HEAD_W:0]    head_inc;

    assign spt_eff    = (spt > SPT_CAP) ? SPT_CAP : spt;
    assign track_left = spt_eff - sec0_reg;
    assign take       = (cnt_reg < {1'b0, track_left}) ? cnt_reg[SPT_W-1:0] : track_left;
    assign bytes      = {{(BYTES_W-SPT_W){1'b0}}, take} << shift;
    assign wrap_sum   = {{(WRAP_W-16){1'b0}}, addr_reg[15:0]}
                      + {1'b0, bytes} - {{(WRAP_W-1){1'b0}}, 1'b1};
    assign head_inc   = {1'b0, head_reg} + 1'b1;

    always_comb begin
        state_next    = state_reg;
        abs_next      = abs_reg;
        carry_next    = carry_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        wr_next       = wr_reg;
        sec0_next     = sec0_reg;
        head_next     = head_reg;
        cyl_next      = cyl_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_cyl_next    = m_cyl_reg;
        m_head_next   = m_head_reg;
        m_sec_next    = m_sec_reg;
        m_cnt_next    = m_cnt_reg;
        m_addr_next   = m_addr_reg;
        m_wrap_next   = m_wrap_reg;
        m_wr_next     = m_wr_reg;
        m_last_next   = m_last_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        div_dividend  = abs_reg;
        div_divisor   = {{(DEN_W-SPT_W){1'b0}}, spt_eff};

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop   = 1'b1;
                    wr_next = q_cmd.wr;
                    if (q_cmd.status != STATUS_OK) begin
                        m_valid_next  = 1'b1;
                        m_status_next = q_cmd.status;
                        m_cyl_next    = '0;
                        m_head_next   = '0;
                        m_sec_next    = '0;
                        m_cnt_next    = '0;
                        m_addr_next   = '0;
                        m_wrap_next   = 1'b0;
                        m_wr_next     = q_cmd.wr;
                        m_last_next   = 1'b1;
                        state_next    = ST_EMIT;
                    end else begin
                        abs_next     = q_cmd.abs_sector;
                        cnt_next     = q_cmd.count;
                        addr_next    = q_cmd.addr;
                        div_start    = 1'b1;
                        div_dividend = q_cmd.abs_sector;
                        state_next   = ST_DIV_SPT;
                    end
                end
            end
            ST_DIV_SPT: begin
                if (div_res.done) begin
                    sec0_next    = div_res.rem[SPT_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = div_res.quot;
                    div_divisor  = heads;
                    state_next   = ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD: begin
                if (div_res.done) begin
                    head_next  = div_res.rem;
                    cyl_next   = div_res.quot;
                    state_next = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                m_valid_next  = 1'b1;
                m_status_next = STATUS_OK;
                m_cyl_next    = cyl_reg;
                m_head_next   = head_reg;
                m_sec_next    = sec0_reg + 1'b1;
                m_cnt_next    = {1'b0, take};
                m_addr_next   = addr_reg;
                m_wrap_next   = (wrap_sum[WRAP_W-1:16] != '0);
                m_wr_next     = wr_reg;
                m_last_next   = (cnt_reg == {1'b0, take});
                cnt_next      = cnt_reg - {1'b0, take};
                {carry_next, abs_next} = {1'b0, abs_reg} + {{(SEC_W+1-SPT_W){1'b0}}, take};
                addr_next     = addr_reg + bytes[ADDR_W-1:0];
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else if (carry_reg) begin
                        // sector address wrapped: track position must be recomputed
                        div_start  = 1'b1;
                        state_next = ST_DIV_SPT;
                    end else begin
                        sec0_next = '0;
                        if (head_inc == {1'b0, heads}) begin
                            head_next = '0;
                            cyl_next  = cyl_reg + 1'b1;
                        end else begin
                            head_next = head_inc[HEAD_W-1:0];
                        end
                        state_next = ST_CHUNK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        abs_reg      <= abs_next;
        carry_reg    <= carry_next;
        cnt_reg      <= cnt_next;
        addr_reg     <= addr_next;
        wr_reg       <= wr_next;
        sec0_reg     <= sec0_next;
        head_reg     <= head_next;
        cyl_reg      <= cyl_next;
        m_status_reg <= m_status_next;
        m_cyl_reg    <= m_cyl_next;
        m_head_reg   <= m_head_next;
        m_sec_reg    <= m_sec_next;
        m_cnt_reg    <= m_cnt_next;
        m_addr_reg   <= m_addr_next;
        m_wrap_reg   <= m_wrap_next;
        m_wr_reg     <= m_wr_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_cylinder      = m_cyl_reg;
    assign m_head          = m_head_reg;
    assign m_sector        = m_sec_reg;
    assign m_chunk_sectors = m_cnt_reg;
    assign m_chunk_address = m_addr_reg;
    assign m_dma_wrap      = m_wrap_reg;
    assign m_write_out     = m_wr_reg;
    assign m_last          = m_last_reg;

`ifndef ASSERT_OFF
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STATUS_OK)) |-> (m_last_reg && (m_cnt_reg == '0)))
        else $error("error result not final or carries sectors");

    a_chunk_in_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STATUS_OK)) |->
        ((m_sec_reg != '0) && (m_cnt_reg != '0) &&
         ({2'b0, m_sec_reg} + {1'b0, m_cnt_reg} - 8'd1 <= {2'b0, spt_eff})))
        else $error("chunk runs past end of track");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE) && !m_valid_reg)
        else $error("request taken while previous one in flight");
`endif

endmodule

>>> rtl/disk_request_chs_splitter_unit.sv
// Channel  Direction  Handshake               Payload
// s_       in         s_valid / s_ready       start_sector, sector_count, buffer_address, is_write
// m_       out        m_valid / m_ready       status, cylinder, head, sector, chunk_sectors,
//                                             chunk_address, dma_wrap, write_out, last
// cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Good request: it leaves the queue, then makes two passes through the shared radix-4 divider
// (16 steps each; sectors per track, then heads); each chunk is built in ST_CHUNK and held
// in ST_EMIT until m_ready takes it, before the next is built; a chunk following a 32-bit
// sector wrap first reruns both divisions. Error results go from ST_IDLE straight to ST_EMIT.
// Requests are checked on entry and held in a two-entry queue; s_ready drops only when full.
// aresetn is synchronous, active low, and restores the register defaults.
module disk_request_chs_splitter_unit
    import dchs_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT,
    parameter int MAX_SPT   = DEF_MAX_SPT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SEC_W-1:0]  s_start_sector,
    input  logic [CNT_W-1:0]  s_sector_count,
    input  logic [ADDR_W-1:0] s_buffer_address,
    input  logic              s_is_write,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [SEC_W-1:0]  m_cylinder,
    output logic [HEAD_W-1:0] m_head,
    output logic [SPT_W-1:0]  m_sector,
    output logic [CNT_W-1:0]  m_chunk_sectors,
    output logic [ADDR_W-1:0] m_chunk_address,
    output logic              m_dma_wrap,
    output logic              m_write_out,
    output logic              m_last
);

    logic [SPT_W-1:0]   spt_reg;
    logic [HEAD_W-1:0]  heads_reg;
    logic [SEC_W-1:0]   pstart_reg;
    logic [SEC_W-1:0]   psize_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic     q_push;
    logic     q_pop;
    logic     q_empty;
    logic     q_full;
    cmd_t     push_cmd;
    cmd_t     pop_cmd;

    logic             div_start;
    logic [NUM_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    div_res_t         div_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg    <= RST_SPT;
            heads_reg  <= RST_HEADS;
            pstart_reg <= RST_PSTART;
            psize_reg  <= RST_PSIZE;
            shift_reg  <= RST_SHIFT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPT:    spt_reg    <= cfg_data[SPT_W-1:0];
                REG_HEADS:  heads_reg  <= cfg_data[HEAD_W-1:0];
                REG_PSTART: pstart_reg <= cfg_data[SEC_W-1:0];
                REG_PSIZE:  psize_reg  <= cfg_data[SEC_W-1:0];
                REG_SHIFT:  shift_reg  <= cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dchs_front #(
        .MAX_COUNT(MAX_COUNT)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_sector  (s_start_sector),
        .s_sector_count  (s_sector_count),
        .s_buffer_address(s_buffer_address),
        .s_is_write      (s_is_write),
        .spt             (spt_reg),
        .heads           (heads_reg),
        .part_start      (pstart_reg),
        .part_size       (psize_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    dchs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .pop     (q_pop),
        .pop_cmd (pop_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    dchs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .res     (div_res)
    );

    dchs_back #(
        .MAX_SPT(MAX_SPT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .spt            (spt_reg),
        .heads          (heads_reg),
        .shift          (shift_reg),
        .q_empty        (q_empty),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .div_start      (div_start),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_res        (div_res),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_cylinder     (m_cylinder),
        .m_head         (m_head),
        .m_sector       (m_sector),
        .m_chunk_sectors(m_chunk_sectors),
        .m_chunk_address(m_chunk_address),
        .m_dma_wrap     (m_dma_wrap),
        .m_write_out    (m_write_out),
        .m_last         (m_last)
    );

endmodule
